### rtl/core/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the byte ring FIFO
// Ring geometry, command and error codes, and the structs passed between
// the control logic and the top level.
// ----------------------------------------------------------------------------
package brf_pkg;

   localparam int CAPACITY = 1023;
   localparam int SLOTS    = CAPACITY + 1;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CMD_W    = 3;
   localparam int LEN_W    = 10;
   localparam int CNT_W    = 10;
   localparam int BYTE_W   = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE     = 3'd0,
      CMD_DEQUEUE     = 3'd1,
      CMD_PEEK        = 3'd2,
      CMD_ADV_FRONT   = 3'd3,
      CMD_ADV_REAR    = 3'd4,
      CMD_CLEAR       = 3'd5,
      CMD_STATUS      = 3'd6,
      CMD_UNUSED      = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_LEN   = 2'd1,
      ERR_SPACE = 2'd2,
      ERR_SEQ   = 2'd3
   } err_type;

   // one request item as seen by the control logic
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data_byte;
      logic              first;
      logic              last;
   } req_item_type;

   // ring memory access for one item
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [IDX_W-1:0]  addr;
      logic [BYTE_W-1:0] wr_data;
   } mem_cmd_type;

   // per-item outcome, known in the accept cycle
   typedef struct packed {
      logic    ok;
      err_type err;
      logic    rd_sel;
   } outcome_type;

   // occupancy derived from the current pointers
   typedef struct packed {
      logic [CNT_W-1:0] used;
      logic [CNT_W-1:0] free;
      logic             full;
      logic             empty;
   } occ_type;

endpackage

### rtl/core/brf_req_if.sv
// ----------------------------------------------------------------------------
// brf_req_if: request channel of the byte ring FIFO
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface brf_req_if;
   import brf_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [LEN_W-1:0]  length;
   logic [BYTE_W-1:0] data_byte;
   logic              first;
   logic              last;

   modport source (output valid, command, length, data_byte, first, last, input ready);
   modport sink   (input valid, command, length, data_byte, first, last, output ready);

endinterface

### rtl/core/brf_rsp_if.sv
// ----------------------------------------------------------------------------
// brf_rsp_if: response channel of the byte ring FIFO
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface brf_rsp_if;
   import brf_pkg::*;

   logic              valid;
   logic              ready;
   logic              ok;
   logic [1:0]        error_code;
   logic [BYTE_W-1:0] read_byte;
   logic [CNT_W-1:0]  used_count;
   logic [CNT_W-1:0]  free_count;
   logic              is_full;
   logic              is_empty;

   modport source (output valid, ok, error_code, read_byte, used_count, free_count,
                   is_full, is_empty, input ready);
   modport sink   (input valid, ok, error_code, read_byte, used_count, free_count,
                   is_full, is_empty, output ready);

endinterface

### rtl/core/byte_ring_fifo.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo: byte FIFO in a ring of CAPACITY+1 slots
// Enqueue/dequeue/peek runs of byte items plus pointer commands; one
// result item per request item.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per handshake: command, length, data_byte,
//   first, last. rsp_chan returns exactly one result item for each request
//   item, in order: ok, error_code, read_byte and the occupancy after the item.
//   An accepted item passes stage 1, then stage 2, before its result shows
//   on rsp_chan. Stage 1 is the decision plus the ring access, stage 2 the
//   output register, loaded with the registered RAM read data.
//   Throughput: one item per cycle while rsp_chan is not held off. The ring
//   is a single-port RAM with one access per item; pointer and run state live
//   in flops, updated in the accept cycle, so the next item sees them at once.
//   A write and a later read of the same slot are always in different cycles,
//   so no forwarding is needed around the RAM.
//   Reset: pointers and run state clear to empty, no run open; the RAM is not
//   cleared (slot contents are undefined until written).
//   Stall: if rsp_chan is held off, the output register holds its item, the
//   stage 1 item waits behind it, and req_chan.ready drops until the output
//   register frees up. Nothing is dropped.
// ----------------------------------------------------------------------------
module byte_ring_fifo (
   input  logic      clock,
   input  logic      reset,
   brf_req_if.sink   req_chan,
   brf_rsp_if.source rsp_chan
);
   import brf_pkg::*;

   req_item_type      item;
   mem_cmd_type       mem_cmd;
   outcome_type       outcome;
   occ_type           occ;
   logic              accept;
   logic              s1_adv;
   logic [BYTE_W-1:0] rd_data;

   // stage 1
   logic        s1_valid_ff, s1_valid_in;
   outcome_type s1_out_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              ok_ff;
   err_type           err_ff;
   logic [BYTE_W-1:0] rbyte_ff;
   occ_type           occ_ff;

   assign item = '{command: req_chan.command, length: req_chan.length,
                   data_byte: req_chan.data_byte, first: req_chan.first,
                   last: req_chan.last};

   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;

   brf_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item    (item),
      .mem_cmd (mem_cmd),
      .outcome (outcome),
      .occ     (occ)
   );

   brf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SLOTS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .rd_en   (mem_cmd.rd_en),
      .addr    (mem_cmd.addr),
      .wr_data (mem_cmd.wr_data),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // occupancy is sampled when stage 1 moves on: pointers then already hold
   // the post-item values and cannot change until the next accept
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_out_ff <= outcome;
      end
      if (s1_adv) begin
         ok_ff    <= s1_out_ff.ok;
         err_ff   <= s1_out_ff.err;
         rbyte_ff <= s1_out_ff.rd_sel ? rd_data : '0;
         occ_ff   <= occ;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ok         = ok_ff;
   assign rsp_chan.error_code = err_ff;
   assign rsp_chan.read_byte  = rbyte_ff;
   assign rsp_chan.used_count = occ_ff.used;
   assign rsp_chan.free_count = occ_ff.free;
   assign rsp_chan.is_full    = occ_ff.full;
   assign rsp_chan.is_empty   = occ_ff.empty;

endmodule

### rtl/core/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram: generic single-port synchronous RAM
// One write or read per cycle; read data registered, held while not reading.
// ----------------------------------------------------------------------------
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/brf_ctrl.sv
// ----------------------------------------------------------------------------
// brf_ctrl: pointer and run control of the byte ring FIFO
// Decides each item in its accept cycle, issues the ring access and
// updates front, rear and run state.
// ----------------------------------------------------------------------------
module brf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  brf_pkg::req_item_type item,
   output brf_pkg::mem_cmd_type  mem_cmd,
   output brf_pkg::outcome_type  outcome,
   output brf_pkg::occ_type      occ
);
   import brf_pkg::*;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] rear_ff, rear_in;
   logic [LEN_W-1:0] offset_ff, offset_in;
   logic [LEN_W-1:0] runlen_ff, runlen_in;
   logic             active_ff, active_in;
   logic             accepted_ff, accepted_in;
   cmd_type          kind_ff, kind_in;

   logic [IDX_W-1:0] used_cur;
   logic [IDX_W-1:0] free_cur;
   cmd_type          cmd;
   logic             go;
   logic [LEN_W-1:0] eff_off;
   logic [LEN_W-1:0] eff_len;
   logic [LEN_W:0]   off_plus;

   // (a + b) mod SLOTS, b below SLOTS
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + (IDX_W+1)'(b);
      if (sum >= (IDX_W+1)'(SLOTS)) begin
         sum = sum - (IDX_W+1)'(SLOTS);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic err_type check_len(input logic [LEN_W-1:0] len,
                                         input logic [IDX_W-1:0] room);
      err_type e;
      e = ERR_NONE;
      if (len == '0 || (LEN_W+1)'(len) > (LEN_W+1)'(CAPACITY)) begin
         e = ERR_LEN;
      end else if ((LEN_W+1)'(len) > (LEN_W+1)'(room)) begin
         e = ERR_SPACE;
      end
      return e;
   endfunction

   always_comb begin
      logic [IDX_W:0] diff;
      if (rear_ff >= front_ff) begin
         diff = {1'b0, rear_ff} - {1'b0, front_ff};
      end else begin
         diff = {1'b0, rear_ff} + (IDX_W+1)'(SLOTS) - {1'b0, front_ff};
      end
      used_cur = diff[IDX_W-1:0];
      free_cur = IDX_W'(CAPACITY) - used_cur;
   end

   assign occ.used  = CNT_W'(used_cur);
   assign occ.free  = CNT_W'(free_cur);
   assign occ.full  = (used_cur == IDX_W'(CAPACITY));
   assign occ.empty = (front_ff == rear_ff);

   assign cmd = cmd_type'(item.command);

   always_comb begin
      front_in    = front_ff;
      rear_in     = rear_ff;
      offset_in   = offset_ff;
      runlen_in   = runlen_ff;
      active_in   = active_ff;
      accepted_in = accepted_ff;
      kind_in     = kind_ff;
      outcome     = '{ok: 1'b0, err: ERR_NONE, rd_sel: 1'b0};
      mem_cmd     = '{wr_en: 1'b0, rd_en: 1'b0, addr: rear_ff, wr_data: item.data_byte};
      go          = 1'b0;
      eff_off     = offset_ff;
      eff_len     = runlen_ff;
      off_plus    = '0;

      if (accept) begin
         case (cmd)
            CMD_ENQUEUE, CMD_DEQUEUE, CMD_PEEK: begin
               if (item.first) begin
                  // a first item drops any open run
                  outcome.err = check_len(item.length,
                                          (cmd == CMD_ENQUEUE) ? free_cur : used_cur);
                  active_in   = 1'b1;
                  accepted_in = 1'b0;
                  offset_in   = '0;
                  runlen_in   = '0;
                  kind_in     = cmd;
                  if (outcome.err == ERR_NONE) begin
                     accepted_in = 1'b1;
                     runlen_in   = item.length;
                     go          = 1'b1;
                     eff_off     = '0;
                     eff_len     = item.length;
                  end else if (item.last) begin
                     active_in = 1'b0;
                  end
               end else if (!active_ff || kind_ff != cmd) begin
                  outcome.err = ERR_SEQ;
                  active_in   = 1'b0;
                  accepted_in = 1'b0;
                  offset_in   = '0;
                  runlen_in   = '0;
               end else if (!accepted_ff) begin
                  // rejected run: swallow items until its end
                  if (item.last) begin
                     active_in = 1'b0;
                     offset_in = '0;
                     runlen_in = '0;
                  end
               end else begin
                  go = 1'b1;
               end

               if (go) begin
                  off_plus = {1'b0, eff_off} + (LEN_W+1)'(1);
                  if (eff_off >= eff_len || (item.last && off_plus != {1'b0, eff_len})) begin
                     outcome.err = ERR_SEQ;
                     active_in   = 1'b0;
                     accepted_in = 1'b0;
                     offset_in   = '0;
                     runlen_in   = '0;
                  end else begin
                     outcome.ok = 1'b1;
                     offset_in  = off_plus[LEN_W-1:0];
                     if (cmd == CMD_ENQUEUE) begin
                        mem_cmd.wr_en = 1'b1;
                        mem_cmd.addr  = ring_add(rear_ff, eff_off);
                     end else begin
                        mem_cmd.rd_en  = 1'b1;
                        mem_cmd.addr   = ring_add(front_ff, eff_off);
                        outcome.rd_sel = 1'b1;
                     end
                     if (item.last) begin
                        if (cmd == CMD_ENQUEUE) begin
                           rear_in = ring_add(rear_ff, eff_len);
                        end else if (cmd == CMD_DEQUEUE) begin
                           front_in = ring_add(front_ff, eff_len);
                        end
                        active_in   = 1'b0;
                        accepted_in = 1'b0;
                        offset_in   = '0;
                        runlen_in   = '0;
                     end
                  end
               end
            end
            CMD_ADV_FRONT, CMD_ADV_REAR: begin
               if (active_ff) begin
                  outcome.err = ERR_SEQ;
               end else begin
                  outcome.err = check_len(item.length,
                                          (cmd == CMD_ADV_FRONT) ? used_cur : free_cur);
                  if (outcome.err == ERR_NONE) begin
                     outcome.ok = 1'b1;
                     if (cmd == CMD_ADV_FRONT) begin
                        front_in = ring_add(front_ff, item.length);
                     end else begin
                        rear_in = ring_add(rear_ff, item.length);
                     end
                  end
               end
            end
            CMD_CLEAR: begin
               front_in    = '0;
               rear_in     = '0;
               active_in   = 1'b0;
               accepted_in = 1'b0;
               offset_in   = '0;
               runlen_in   = '0;
               outcome.ok  = 1'b1;
            end
            CMD_STATUS: begin
               outcome.ok = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         rear_ff     <= '0;
         offset_ff   <= '0;
         runlen_ff   <= '0;
         active_ff   <= 1'b0;
         accepted_ff <= 1'b0;
         kind_ff     <= CMD_ENQUEUE;
      end else begin
         front_ff    <= front_in;
         rear_ff     <= rear_in;
         offset_ff   <= offset_in;
         runlen_ff   <= runlen_in;
         active_ff   <= active_in;
         accepted_ff <= accepted_in;
         kind_ff     <= kind_in;
      end
   end

endmodule
